// File: rtl/core/box_blur_3x3_rgb_defines.svh
// box_blur_3x3_rgb_defines.svh: assertion macros for the box blur checker.
// No dependencies; included by bb3_checker.sv.
`ifndef BOX_BLUR_3X3_RGB_DEFINES_SVH
`define BOX_BLUR_3X3_RGB_DEFINES_SVH

// Same-cycle implication, gated by the active-low synchronous reset.
`define BB3_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, gated by the active-low synchronous reset.
`define BB3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/bb3_pkg.sv
// bb3_pkg.sv: shared widths, codes and control structs of the box blur block.
// No dependencies; first compiled file of rtl/core.
`default_nettype none

package bb3_pkg;

    localparam int CH_W      = 8;                 // one color channel
    localparam int PIX_W     = 3 * CH_W;          // packed {red, green, blue}
    localparam int CFG_W     = 11;                // register data width
    localparam int CFG_IDX_W = 1;                 // two registers
    localparam int SUM_W     = 12;                // up to 9 * 255
    localparam int NUM_W     = SUM_W + 1;         // 2 * sum + count
    localparam int CNT9_W    = 4;                 // neighbor count, 0..9
    localparam int DEN_W     = CNT9_W + 1;        // 2 * count
    localparam int Q_W       = CH_W;              // quotient bits
    localparam int DSH_W     = DEN_W + Q_W - 1;   // divisor aligned to the top quotient bit
    localparam int STEP_W    = $clog2(Q_W + 1);

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;
    localparam logic [CFG_W-1:0]     CFG_DIM_RESET    = 11'd1024;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    typedef logic [PIX_W-1:0] t_pix;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch input item, read both line stores
        logic shift;     // write line stores, shift window, step position
        logic sum;       // sum window, start dividers
        logic load_out;  // move quotients into the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic item_ok;   // offered item is not ignored
        logic emit;      // current item produces a result
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// File: rtl/core/bb3_in_if.sv
// bb3_in_if.sv: valid/ready channel carrying one input item (pixel or drain).
// Depends on bb3_pkg.
`default_nettype none

interface bb3_in_if;
    import bb3_pkg::*;

    logic            valid;
    logic            ready;
    logic            mode;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;

    modport source (output valid, mode, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, mode, red_in, green_in, blue_in, output ready);
endinterface

`default_nettype wire

// File: rtl/core/bb3_out_if.sv
// bb3_out_if.sv: valid/ready channel carrying one blurred pixel.
// Depends on bb3_pkg.
`default_nettype none

interface bb3_out_if;
    import bb3_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic            frame_end;

    modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

`default_nettype wire

// File: rtl/core/bb3_div.sv
// bb3_div.sv: restoring divider, one quotient bit per cycle, for one channel.
// Depends on bb3_pkg. Quotient must fit in Q_W bits (num < den << Q_W).
`default_nettype none

module bb3_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [bb3_pkg::NUM_W-1:0]  i_num,
    input  logic [bb3_pkg::DEN_W-1:0]  i_den,
    output logic [bb3_pkg::Q_W-1:0]    o_quot,
    output logic                       o_done
);
    import bb3_pkg::*;

    logic [NUM_W-1:0]  r_rem;
    logic [DSH_W-1:0]  r_dsh;
    logic [Q_W-1:0]    r_quot;
    logic [STEP_W-1:0] r_step;
    logic              fits;

    assign fits = (r_rem >= NUM_W'(r_dsh));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_start) begin
            r_step <= STEP_W'(Q_W);
        end else if (r_step != '0) begin
            r_step <= r_step - STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_dsh  <= {i_den, {(Q_W-1){1'b0}}};
            r_quot <= '0;
        end else if (r_step != '0) begin
            if (fits) begin
                r_rem <= r_rem - NUM_W'(r_dsh);
            end
            r_quot <= {r_quot[Q_W-2:0], fits};
            r_dsh  <= r_dsh >> 1;
        end
    end

    assign o_quot = r_quot;
    assign o_done = (r_step == '0);

endmodule

`default_nettype wire

// File: rtl/core/bb3_datapath.sv
// bb3_datapath.sv: configuration, line stores, 3x3 window, position counters,
// neighbor sums, three channel dividers and the output register.
// Depends on bb3_pkg and bb3_div.
`default_nettype none

module bb3_datapath #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bb3_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bb3_pkg::CFG_W-1:0]     i_cfg_data,
    input  bb3_pkg::t_cmd                 i_cmd,
    output bb3_pkg::t_stat                o_stat,
    input  logic                          i_mode,
    input  logic [bb3_pkg::CH_W-1:0]      i_red,
    input  logic [bb3_pkg::CH_W-1:0]      i_green,
    input  logic [bb3_pkg::CH_W-1:0]      i_blue,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [bb3_pkg::CH_W-1:0]      o_red,
    output logic [bb3_pkg::CH_W-1:0]      o_green,
    output logic [bb3_pkg::CH_W-1:0]      o_blue,
    output logic                          o_frame_end
);
    import bb3_pkg::*;

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;  // column / address
    localparam int WW = $clog2(MAX_WIDTH + 1);                     // width value
    localparam int HW = $clog2(MAX_HEIGHT + 1);                    // height value
    localparam int RW = $clog2(MAX_HEIGHT + 2);                    // row, runs to h+1 in drain
    localparam int PW = $clog2(MAX_WIDTH + 2);                     // drain items pending

    // configuration
    logic [CFG_W-1:0] r_cfg_w;
    logic [CFG_W-1:0] r_cfg_h;
    logic [WW-1:0]    w_eff;
    logic [HW-1:0]    h_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= CFG_DIM_RESET;
            r_cfg_h <= CFG_DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FRAME_WIDTH:  r_cfg_w <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_cfg_h <= i_cfg_data;
            endcase
        end
    end

    always_comb begin
        if (r_cfg_w == '0) begin
            w_eff = WW'(1);
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            h_eff = HW'(1);
        end else if (32'(r_cfg_h) > MAX_HEIGHT) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(r_cfg_h);
        end
    end

    // position and drain bookkeeping
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [PW-1:0] r_pend;
    logic [CW-1:0] x_eff;

    assign x_eff = (WW'(r_col) >= w_eff) ? '0 : r_col;
    assign o_stat.item_ok = ((i_mode == MODE_PIXEL) == (r_pend == '0));

    // item capture and line stores
    t_pix          older_store [MAX_WIDTH];
    t_pix          newer_store [MAX_WIDTH];
    t_pix          r_pix;
    t_pix          r_top;
    t_pix          r_mid;
    logic          r_mode;
    logic [CW-1:0] r_addr;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pix  <= (i_mode == MODE_DRAIN) ? '0 : {i_red, i_green, i_blue};
            r_mode <= i_mode;
            r_addr <= x_eff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_top <= older_store[x_eff];
        end
        if (i_cmd.shift) begin
            older_store[r_addr] <= r_mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mid <= newer_store[x_eff];
        end
        if (i_cmd.shift) begin
            newer_store[r_addr] <= r_pix;
        end
    end

    // next position
    logic [WW-1:0] x_inc;
    logic          wrap;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;

    assign x_inc = WW'(r_addr) + WW'(1);
    assign wrap  = (x_inc >= w_eff);
    assign n_col = wrap ? '0 : CW'(x_inc);
    assign n_row = wrap ? r_row + RW'(1) : r_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_pend <= '0;
        end else if (i_cfg_we) begin
            r_col  <= '0;
            r_row  <= '0;
            r_pend <= '0;
        end else if (i_cmd.shift) begin
            r_col <= n_col;
            r_row <= n_row;
            if (r_mode == MODE_PIXEL) begin
                if (n_row >= RW'(h_eff)) begin
                    r_pend <= PW'(w_eff) + PW'(1);
                end
            end else if (r_pend == PW'(1)) begin
                // last drain item: frame restarts
                r_pend <= '0;
                r_col  <= '0;
                r_row  <= '0;
            end else begin
                r_pend <= r_pend - PW'(1);
            end
        end
    end

    // centre of the result window and which neighbors lie inside the frame
    logic          emit;
    logic [RW-1:0] py;
    logic [WW-1:0] px;
    logic [RW:0]   py_x;
    logic [RW:0]   h_x;
    logic [WW:0]   px_x;
    logic [WW:0]   w_x;
    logic [2:0]    row_in;
    logic [2:0]    col_in;
    logic [8:0]    n_mask;
    logic          fend;

    assign emit = (r_row >= RW'(2)) || ((r_row == RW'(1)) && (r_addr != '0));
    assign py   = (r_addr != '0) ? r_row - RW'(1) : r_row - RW'(2);
    assign px   = (r_addr != '0) ? WW'(r_addr) - WW'(1) : w_eff - WW'(1);
    assign py_x = (RW+1)'(py);
    assign h_x  = (RW+1)'(h_eff);
    assign px_x = (WW+1)'(px);
    assign w_x  = (WW+1)'(w_eff);

    assign row_in[0] = (py != '0) && ((py_x - (RW+1)'(1)) < h_x);
    assign row_in[1] = (py_x < h_x);
    assign row_in[2] = ((py_x + (RW+1)'(1)) < h_x);
    assign col_in[0] = (px != '0);
    assign col_in[1] = (px_x < w_x);
    assign col_in[2] = ((px_x + (WW+1)'(1)) < w_x);
    assign fend = (py_x == h_x - (RW+1)'(1)) && (px_x == w_x - (WW+1)'(1));

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                n_mask[r*3 + c] = row_in[r] & col_in[c];
            end
        end
    end

    // window: index row*3 + col, column 2 is the newest
    t_pix       r_win [9];
    logic [8:0] r_mask;
    logic       r_emit;
    logic       r_fend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else if (i_cmd.shift) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r*3]     <= r_win[r*3 + 1];
                r_win[r*3 + 1] <= r_win[r*3 + 2];
            end
            r_win[2] <= r_top;
            r_win[5] <= r_mid;
            r_win[8] <= r_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit <= 1'b0;
        end else if (i_cmd.shift) begin
            r_emit <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_mask <= n_mask;
            r_fend <= fend;
        end
    end

    assign o_stat.emit = r_emit;

    // neighbor sums; rounding half up is (2*sum + n) / (2*n)
    logic [SUM_W-1:0]  sum_r;
    logic [SUM_W-1:0]  sum_g;
    logic [SUM_W-1:0]  sum_b;
    logic [CNT9_W-1:0] cnt;
    logic [CNT9_W-1:0] cnt_fix;
    logic [DEN_W-1:0]  den;

    always_comb begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        cnt   = '0;
        for (int k = 0; k < 9; k++) begin
            if (r_mask[k]) begin
                sum_r = sum_r + SUM_W'(r_win[k][PIX_W-1 -: CH_W]);
                sum_g = sum_g + SUM_W'(r_win[k][2*CH_W-1 -: CH_W]);
                sum_b = sum_b + SUM_W'(r_win[k][CH_W-1:0]);
                cnt   = cnt + CNT9_W'(1);
            end
        end
    end

    assign cnt_fix = (cnt == '0) ? CNT9_W'(1) : cnt;
    assign den     = {cnt_fix, 1'b0};

    logic [CH_W-1:0] q_r;
    logic [CH_W-1:0] q_g;
    logic [CH_W-1:0] q_b;
    logic [2:0]      done;

    bb3_div u_div_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sum),
        .i_num   ({sum_r, 1'b0} + NUM_W'(cnt_fix)),
        .i_den   (den),
        .o_quot  (q_r),
        .o_done  (done[0])
    );

    bb3_div u_div_g (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sum),
        .i_num   ({sum_g, 1'b0} + NUM_W'(cnt_fix)),
        .i_den   (den),
        .o_quot  (q_g),
        .o_done  (done[1])
    );

    bb3_div u_div_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sum),
        .i_num   ({sum_b, 1'b0} + NUM_W'(cnt_fix)),
        .i_den   (den),
        .o_quot  (q_b),
        .o_done  (done[2])
    );

    assign o_stat.div_done = &done;

    // output register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_red       <= q_r;
            o_green     <= q_g;
            o_blue      <= q_b;
            o_frame_end <= r_fend;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

endmodule

`default_nettype wire

// File: rtl/core/bb3_ctrl.sv
// bb3_ctrl.sv: sequencer of the box blur: accept, update, sum, divide, emit.
// Depends on bb3_pkg.
`default_nettype none

module bb3_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  bb3_pkg::t_stat i_stat,
    output bb3_pkg::t_cmd  o_cmd
);
    import bb3_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SHIFT = 2'd1;
    localparam logic [1:0] S_SUM   = 2'd2;
    localparam logic [1:0] S_DIV   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_in_valid;
                // ignored items finish in the transfer cycle
                if (i_in_valid && i_stat.item_ok) begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                o_cmd.shift = 1'b1;
                n_state     = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = i_stat.emit ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                if (i_stat.div_done && i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

// File: rtl/core/box_blur_3x3_rgb.sv
// box_blur_3x3_rgb.sv: top level of the streaming 3x3 RGB box blur.
// Depends on bb3_pkg, bb3_in_if, bb3_out_if, bb3_ctrl, bb3_datapath.
//
// Usage:
//   i_pix carries raster-order pixels (mode 0) and drain items (mode 1), o_pix
//   the blurred pixels. A transfer happens when valid and ready are both high.
//   Each result is the rounded mean of the in-frame 3x3 neighborhood and lags
//   its input by one row plus one pixel; after the last pixel of a frame send
//   frame_width+1 drain items, the final result carries frame_end.
//   Registers (i_cfg_we/i_cfg_idx/i_cfg_data): 0 = frame_width, 1 = frame_height;
//   a write restarts the frame position. Write only while the block is idle.
// Sequence:
//   An item that produces a result occupies the block through transfer,
//   line-store update, neighbor sum, division (one quotient bit per divider
//   step) and output load; then result valid and i_pix.ready return together.
//   A no-result item ends after the neighbor sum, an ignored item at its transfer.
//   The output register holds a finished result while o_pix.ready is low; the
//   next item is still taken and waits after division until the register frees.
// Reset: synchronous, active low; clears position, drain count, window and
//   both registers to 1024. Line store contents are not cleared.
`default_nettype none

module box_blur_3x3_rgb #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bb3_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bb3_pkg::CFG_W-1:0]     i_cfg_data,
    bb3_in_if.sink                        i_pix,
    bb3_out_if.source                     o_pix
);
    import bb3_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    bb3_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pix.valid),
        .o_in_ready (i_pix.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bb3_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_mode      (i_pix.mode),
        .i_red       (i_pix.red_in),
        .i_green     (i_pix.green_in),
        .i_blue      (i_pix.blue_in),
        .i_out_ready (o_pix.ready),
        .o_out_valid (o_pix.valid),
        .o_red       (o_pix.red_out),
        .o_green     (o_pix.green_out),
        .o_blue      (o_pix.blue_out),
        .o_frame_end (o_pix.frame_end)
    );

endmodule

`default_nettype wire

// File: rtl/core/bb3_checker.sv
// bb3_checker.sv: port-level assertions for box_blur_3x3_rgb, bound to the top.
// Depends on bb3_pkg and box_blur_3x3_rgb_defines.svh.
`default_nettype none
`include "box_blur_3x3_rgb_defines.svh"

module bb3_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     i_in_ready,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic [bb3_pkg::CH_W-1:0] i_out_red,
    input logic [bb3_pkg::CH_W-1:0] i_out_green,
    input logic [bb3_pkg::CH_W-1:0] i_out_blue,
    input logic                     i_out_frame_end
);
    import bb3_pkg::*;

    logic in_xfer;
    logic out_stall;

    assign in_xfer   = i_in_valid && i_in_ready;
    assign out_stall = i_out_valid && !i_out_ready;

    // a stalled result is neither dropped nor altered
    `BB3_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid, "result dropped while stalled")
    `BB3_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, out_stall, $stable(i_out_red) && $stable(i_out_green) && $stable(i_out_blue) && $stable(i_out_frame_end), "stalled result changed")

    // a new result needs the divider to finish, so no input transfer just before it
    `BB3_ASSERT_SAME(a_no_instant_result, i_clk, i_rst_n, $rose(i_out_valid), !$past(in_xfer), "result appeared right after an input transfer")

endmodule

bind box_blur_3x3_rgb bb3_checker u_bb3_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_pix.valid),
    .i_in_ready      (i_pix.ready),
    .i_out_valid     (o_pix.valid),
    .i_out_ready     (o_pix.ready),
    .i_out_red       (o_pix.red_out),
    .i_out_green     (o_pix.green_out),
    .i_out_blue      (o_pix.blue_out),
    .i_out_frame_end (o_pix.frame_end)
);

`default_nettype wire

// File: tb/box_blur_3x3_rgb_test.sv
// box_blur_3x3_rgb_test.sv: self-checking bench for the streaming 3x3 RGB box blur.
// Needs bb3_pkg, bb3_in_if, bb3_out_if and box_blur_3x3_rgb; a predictor inside the
// bench computes every blurred pixel, a directed table runs first, then random frames.
module box_blur_3x3_rgb_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bb3_pkg::*;

    localparam int MAX_W        = 1024;
    localparam int MAX_H        = 1024;
    localparam int QUIET_CYCLES = 20;     // covers a full result-producing item plus slack
    localparam int RANDOM_ITEMS = 900;
    localparam int DIR_ROWS     = 25;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            frame_end;
    } blur_px_t;

    typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_e;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

    typedef struct packed {
        row_kind_e             kind;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_W-1:0]      reg_val;
        logic                  mode;
        t_pix                  pixel;
        logic                  typed;       // expectation written in the row
        logic                  exp_valid;
        blur_px_t              exp_px;
    } dir_row_t;

    localparam blur_px_t NO_BLUR = '0;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    bb3_in_if  pix_in_ch();
    bb3_out_if pix_out_ch();

    box_blur_3x3_rgb #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_in_ch),
        .o_pix      (pix_out_ch)
    );

    // predictor state
    t_pix             line_top [MAX_W];    // row two above the current position
    t_pix             line_mid [MAX_W];    // row directly above
    t_pix             win [9];
    int               col_pos;
    int               row_pos;
    int               drains_left;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    blur_px_t blurred_q [$];
    dir_row_t dir_rows [DIR_ROWS];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int mismatches     = 0;
    int results_seen   = 0;
    int items_taken    = 0;
    int items_ignored  = 0;
    int frames_run     = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(5_000_000);
        $display("FAIL box_blur_3x3_rgb");
        $finish;
    end

    function automatic int clamp_dim(input logic [CFG_W-1:0] v, input int lim);
        if (v == 0) return 1;
        if (int'(v) > lim) return lim;
        return int'(v);
    endfunction

    // Returns 1 when the item yields a blurred pixel; taken is 0 for ignored items.
    function automatic bit blur_predict(input logic mode, input t_pix px_in,
                                        output bit taken, output blur_px_t res);
        int   w, h, x, y, cy, cx, ny, nx, cnt, sum_r, sum_g, sum_b;
        t_pix pix, top, mid, p;
        bit   emit;
        res   = NO_BLUR;
        taken = 1'b0;
        w = clamp_dim(width_reg, MAX_W);
        h = clamp_dim(height_reg, MAX_H);
        if (mode == MODE_DRAIN && drains_left == 0) return 1'b0;
        if (mode == MODE_PIXEL && drains_left != 0) return 1'b0;
        taken = 1'b1;
        x = col_pos;
        y = row_pos;
        if (x >= w) x = 0;
        pix = (mode == MODE_PIXEL) ? px_in : '0;
        top = line_top[x];
        mid = line_mid[x];
        line_top[x] = mid;
        line_mid[x] = pix;
        for (int r = 0; r < 3; r++) begin
            win[r*3]   = win[r*3+1];
            win[r*3+1] = win[r*3+2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = pix;
        emit = (y >= 2) || (y == 1 && x >= 1);
        if (emit) begin
            // window center sits one row and one column behind the input
            if (x >= 1) begin
                cy = y - 1;
                cx = x - 1;
            end else begin
                cy = y - 2;
                cx = w - 1;
            end
            cnt   = 0;
            sum_r = 0;
            sum_g = 0;
            sum_b = 0;
            for (int dy = -1; dy <= 1; dy++) begin
                for (int dx = -1; dx <= 1; dx++) begin
                    ny = cy + dy;
                    nx = cx + dx;
                    if (ny >= 0 && ny < h && nx >= 0 && nx < w) begin
                        p = win[(dy+1)*3 + dx + 1];
                        sum_r += p[23:16];
                        sum_g += p[15:8];
                        sum_b += p[7:0];
                        cnt++;
                    end
                end
            end
            res.red       = CH_W'((2*sum_r + cnt) / (2*cnt));
            res.green     = CH_W'((2*sum_g + cnt) / (2*cnt));
            res.blue      = CH_W'((2*sum_b + cnt) / (2*cnt));
            res.frame_end = (cy == h - 1 && cx == w - 1);
        end
        x++;
        if (x >= w) begin
            x = 0;
            y++;
        end
        col_pos = x;
        row_pos = y;
        if (mode == MODE_PIXEL) begin
            if (y >= h) drains_left = w + 1;
        end else begin
            drains_left--;
            if (drains_left == 0) begin
                col_pos = 0;
                row_pos = 0;
            end
        end
        return emit;
    endfunction

    function automatic t_pix rand_pix();
        t_pix p;
        for (int c = 0; c < 3; c++) begin
            case ($urandom_range(7))
                0:       p[c*8 +: 8] = 8'h00;
                1:       p[c*8 +: 8] = 8'hff;
                default: p[c*8 +: 8] = 8'($urandom_range(255));
            endcase
        end
        return p;
    endfunction

    task automatic set_idle(input idle_mode_e ph);
        src_idle_pct   = (ph == IDLE_SENDER)   ? 59 : (ph == IDLE_BOTH) ? 32 : 0;
        sink_stall_pct = (ph == IDLE_RECEIVER) ? 59 : (ph == IDLE_BOTH) ? 32 : 0;
    endtask

    // Holds the sender off until every outstanding blurred pixel has come back.
    task automatic wait_until_quiet();
        pix_in_ch.valid <= 1'b0;
        while (blurred_q.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_FRAME_WIDTH) width_reg = val;
        else height_reg = val;
        col_pos     = 0;
        row_pos     = 0;
        drains_left = 0;
        @(posedge i_clk);
    endtask

    task automatic send_item(input logic mode, input t_pix px,
                             output bit emit, output blur_px_t res);
        bit taken;
        if ($urandom_range(99) < src_idle_pct) begin
            pix_in_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        pix_in_ch.valid    <= 1'b1;
        pix_in_ch.mode     <= mode;
        pix_in_ch.red_in   <= px[23:16];
        pix_in_ch.green_in <= px[15:8];
        pix_in_ch.blue_in  <= px[7:0];
        do @(posedge i_clk); while (!pix_in_ch.ready);
        emit = blur_predict(mode, px, taken, res);
        if (taken) items_taken++;
        else items_ignored++;
    endtask

    // One frame of raster pixels and its drain items, with a few stray items of the
    // wrong kind mixed in; cut_short stops it partway so the next write restarts it.
    task automatic run_frame(input logic [CFG_W-1:0] w_val, input logic [CFG_W-1:0] h_val,
                             input bit rewrite, input bit cut_short);
        int       w, h, n_slots, k;
        bit       noise, emit;
        logic     slot_mode, m;
        blur_px_t res;
        w = clamp_dim(w_val, MAX_W);
        h = clamp_dim(h_val, MAX_H);
        if (rewrite) begin
            wait_until_quiet();
            write_reg(CFG_FRAME_WIDTH, w_val);
            write_reg(CFG_FRAME_HEIGHT, h_val);
        end
        n_slots = w*h + w + 1;
        if (cut_short) n_slots = $urandom_range(n_slots - 1, 1);
        k = 0;
        while (k < n_slots) begin
            slot_mode = (k < w*h) ? MODE_PIXEL : MODE_DRAIN;
            noise     = ($urandom_range(99) < 4);
            m         = noise ? ~slot_mode : slot_mode;
            send_item(m, rand_pix(), emit, res);
            if (emit) blurred_q.push_back(res);
            if (!noise) k++;
        end
        frames_run++;
    endtask

    // result side: random stalls, compare against the oldest expectation
    initial begin : result_side
        blur_px_t got, want;
        pix_out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pix_out_ch.valid && pix_out_ch.ready) begin
                got = {pix_out_ch.red_out, pix_out_ch.green_out, pix_out_ch.blue_out,
                       pix_out_ch.frame_end};
                results_seen++;
                if (blurred_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected blurred pixel r=%02h g=%02h b=%02h end=%0b",
                                 got.red, got.green, got.blue, got.frame_end);
                end else begin
                    want = blurred_q.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue || got.frame_end !== want.frame_end) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp r=%02h g=%02h b=%02h end=%0b, ",
                                      "got %02h %02h %02h %0b"},
                                     want.red, want.green, want.blue, want.frame_end,
                                     got.red, got.green, got.blue, got.frame_end);
                    end
                end
            end
            pix_out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial begin : stimulus
        bit               emit, cut, prev_cut;
        blur_px_t         res;
        dir_row_t         row;
        int               base, frame_no;
        logic [CFG_W-1:0] cur_w, cur_h;

        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= CFG_FRAME_WIDTH;
        i_cfg_data         <= '0;
        pix_in_ch.valid    <= 1'b0;
        pix_in_ch.mode     <= MODE_PIXEL;
        pix_in_ch.red_in   <= '0;
        pix_in_ch.green_in <= '0;
        pix_in_ch.blue_in  <= '0;

        width_reg   = CFG_DIM_RESET;
        height_reg  = CFG_DIM_RESET;
        col_pos     = 0;
        row_pos     = 0;
        drains_left = 0;
        foreach (line_top[i]) begin
            line_top[i] = '0;
            line_mid[i] = '0;
        end
        foreach (win[i]) win[i] = '0;

        // 1x1 frames (zero dims act as one): the result is the pixel itself.
        // Covers stray items, ignored drain data and the silent first drain.
        dir_rows = '{
            {ROW_CFG,  CFG_FRAME_WIDTH,  11'd0, MODE_PIXEL, 24'h000000, 1'b1, 1'b0, NO_BLUR},
            {ROW_CFG,  CFG_FRAME_HEIGHT, 11'd0, MODE_PIXEL, 24'h000000, 1'b1, 1'b0, NO_BLUR},
            {ROW_ITEM, CFG_FRAME_WIDTH,  11'd0, MODE_PIXEL, 24'hffffff, 1'b1, 1'b0, NO_BLUR},
            {ROW_ITEM, CFG_FRAME_WIDTH,  11'd0, MODE_DRAIN, 24'h000000, 1'b1, 1'b0, NO_BLUR},
            // pixel during drain is dropped
            {ROW_ITEM, CFG_FRAME_WIDTH,  11'd0, MODE_PIXEL, 24'h000000, 1'b1, 1'b0, NO_BLUR},
            {ROW_ITEM, CFG_FRAME_WIDTH,  11'd0, MODE_DRAIN, 24'hffffff, 1'b1, 1'b1,
             {8'hff, 8'hff, 8'hff, 1'b1}},
            // drain with no frame pending is dropped
            {ROW_ITEM, CFG_FRAME_WIDTH,  11'd0, MODE_DRAIN, 24'h123456, 1'b1, 1'b0, NO_BLUR},
            {ROW_ITEM, CFG_FRAME_WIDTH,  11'd0, MODE_PIXEL, 24'h807f01, 1'b1, 1'b0, NO_BLUR},
            {ROW_ITEM, CFG_FRAME_WIDTH,  11'd0, MODE_DRAIN, 24'h000000, 1'b1, 1'b0, NO_BLUR},
            {ROW_ITEM, CFG_FRAME_WIDTH,  11'd0, MODE_DRAIN, 24'h000000, 1'b1, 1'b1,
             {8'h80, 8'h7f, 8'h01, 1'b1}},
            // 3x3 frame: corner, edge and full-window divisors
            {ROW_CFG,  CFG_FRAME_WIDTH,  11'd3, MODE_PIXEL, 24'h000000, 1'b0, 1'b0, NO_BLUR},
            {ROW_CFG,  CFG_FRAME_HEIGHT, 11'd3, MODE_PIXEL, 24'h000000, 1'b0, 1'b0, NO_BLUR},
            {ROW_ITEM, CFG_FRAME_WIDTH,  11'd0, MODE_PIXEL, 24'hffffff, 1'b0, 1'b0, NO_BLUR},
            {ROW_ITEM, CFG_FRAME_WIDTH,  11'd0, MODE_PIXEL, 24'h000000, 1'b0, 1'b0, NO_BLUR},
            {ROW_ITEM, CFG_FRAME_WIDTH,  11'd0, MODE_PIXEL, 24'hff00ff, 1'b0, 1'b0, NO_BLUR},
            {ROW_ITEM, CFG_FRAME_WIDTH,  11'd0, MODE_PIXEL, 24'h00ff00, 1'b0, 1'b0, NO_BLUR},
            {ROW_ITEM, CFG_FRAME_WIDTH,  11'd0, MODE_PIXEL, 24'h7f8001, 1'b0, 1'b0, NO_BLUR},
            {ROW_ITEM, CFG_FRAME_WIDTH,  11'd0, MODE_PIXEL, 24'hfefefe, 1'b0, 1'b0, NO_BLUR},
            {ROW_ITEM, CFG_FRAME_WIDTH,  11'd0, MODE_PIXEL, 24'h010203, 1'b0, 1'b0, NO_BLUR},
            {ROW_ITEM, CFG_FRAME_WIDTH,  11'd0, MODE_PIXEL, 24'hff0000, 1'b0, 1'b0, NO_BLUR},
            {ROW_ITEM, CFG_FRAME_WIDTH,  11'd0, MODE_PIXEL, 24'h00ffff, 1'b0, 1'b0, NO_BLUR},
            {ROW_ITEM, CFG_FRAME_WIDTH,  11'd0, MODE_DRAIN, 24'h000000, 1'b0, 1'b0, NO_BLUR},
            {ROW_ITEM, CFG_FRAME_WIDTH,  11'd0, MODE_DRAIN, 24'hffffff, 1'b0, 1'b0, NO_BLUR},
            {ROW_ITEM, CFG_FRAME_WIDTH,  11'd0, MODE_DRAIN, 24'h5a5a5a, 1'b0, 1'b0, NO_BLUR},
            {ROW_ITEM, CFG_FRAME_WIDTH,  11'd0, MODE_DRAIN, 24'ha5a5a5, 1'b0, 1'b0, NO_BLUR}
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_idle(IDLE_NONE);
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.kind == ROW_CFG) begin
                wait_until_quiet();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                send_item(row.mode, row.pixel, emit, res);
                if (row.typed) begin
                    if (row.exp_valid) blurred_q.push_back(row.exp_px);
                end else if (emit) begin
                    blurred_q.push_back(res);
                end
            end
        end

        // random frames, mostly small, cycling through the idling phases
        cur_w    = 11'd3;
        cur_h    = 11'd3;
        prev_cut = 1'b0;
        frame_no = 0;
        base     = items_taken;
        while (items_taken - base < RANDOM_ITEMS) begin
            set_idle(idle_mode_e'((frame_no / 3) % 4));
            cut = ($urandom_range(7) == 0);
            if (prev_cut || $urandom_range(3) != 0) begin
                case ($urandom_range(19))
                    0:       cur_w = 11'd0;
                    1, 2:    cur_w = CFG_W'($urandom_range(40, 17));
                    default: cur_w = CFG_W'($urandom_range(8, 1));
                endcase
                case ($urandom_range(19))
                    0:       cur_h = 11'd0;
                    1:       cur_h = CFG_W'($urandom_range(20, 9));
                    default: cur_h = CFG_W'($urandom_range(6, 1));
                endcase
                run_frame(cur_w, cur_h, 1'b1, cut);
            end else begin
                run_frame(cur_w, cur_h, 1'b0, cut);
            end
            prev_cut = cut;
            frame_no++;
        end

        wait_until_quiet();

        $display("Sent %0d accepted items (%0d more dropped by the block) over %0d frames;",
                 items_taken, items_ignored, frames_run);
        $display("compared %0d blurred pixels, %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0 && blurred_q.size() == 0) begin
            $display("PASS box_blur_3x3_rgb");
        end else begin
            $display("FAIL box_blur_3x3_rgb");
        end
        $finish;
    end

endmodule
